>>> sv/sws_pkg.sv
// Shared widths, register indexes, defaults and types for the sliding window statistics block.
package sws_pkg;

  // Field widths, fixed by the item and result formats.
  localparam int CMD_W  = 1;
  localparam int WORD_W = 32;
  localparam int LOOK_W = 6;
  localparam int CNT_W  = 7;
  localparam int SUM_W  = 38;

  // Configuration port geometry.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register indexes, taken from byte address bit 2.
  localparam logic REG_WINDOW_SIZE   = 1'b0;
  localparam logic REG_PARTIAL_COUNT = 1'b1;

  // Register reset values.
  localparam logic [CNT_W-1:0] WINDOW_SIZE_RESET   = 7'd0;
  localparam logic [CNT_W-1:0] PARTIAL_COUNT_RESET = 7'd1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_REPORT = 1'b1;

  // Parameter defaults.
  localparam int DEF_MAX_WINDOW  = 64;
  localparam int DEF_SAMPLE_BITS = 32;

  // Status of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> sv/sws_item_if.sv
// Input channel interface: one transaction carries a command, a sample and a lookback.
interface sws_item_if;
  import sws_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [WORD_W-1:0] sample;
  logic [LOOK_W-1:0] lookback;

  modport source (output valid, command, sample, lookback, input ready);
  modport sink   (input valid, command, sample, lookback, output ready);
endinterface

>>> sv/sws_result_if.sv
// Result channel interface: one transaction carries the window statistics.
interface sws_result_if;
  import sws_pkg::*;

  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  filled;
  logic [SUM_W-1:0]  window_sum;
  logic [WORD_W-1:0] window_mean;
  logic [WORD_W-1:0] window_min;
  logic [WORD_W-1:0] newest;
  logic [WORD_W-1:0] oldest;
  logic [SUM_W-1:0]  partial_sum;
  logic [WORD_W-1:0] peek_value;

  modport source (output valid, filled, window_sum, window_mean, window_min, newest, oldest,
                  partial_sum, peek_value, input ready);
  modport sink   (input valid, filled, window_sum, window_mean, window_min, newest, oldest,
                  partial_sum, peek_value, output ready);
endinterface

>>> sv/sws_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/sws_div.sv
// Bit-serial restoring divider: a sum-wide dividend by a count-wide divisor.
module sws_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [sws_pkg::SUM_W-1:0] dividend,
  input  logic [sws_pkg::CNT_W-1:0] divisor,
  output logic [sws_pkg::SUM_W-1:0] quotient,
  output logic [sws_pkg::CNT_W-1:0] remainder,
  output sws_pkg::div_stat_t        stat
);
  import sws_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;

  logic [CNT_W:0]    trial;
  logic              fits;
  logic [CNT_W-1:0]  rem_next;

  // One quotient bit per cycle: shift in the next dividend bit and try the subtract.
  always_comb begin
    trial    = {rem, quo[SUM_W-1]};
    fits     = trial >= {1'b0, dvs};
    rem_next = fits ? CNT_W'(trial - {1'b0, dvs}) : trial[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        quo   <= dividend;
        rem   <= '0;
        dvs   <= divisor;
        steps <= STEP_W'(SUM_W);
        busy  <= 1'b1;
      end else if (busy) begin
        quo   <= {quo[SUM_W-2:0], fits};
        rem   <= rem_next;
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign stat      = '{busy: busy, done: done};

endmodule

>>> sv/sliding_window_stats.sv
// Top level of the sliding window statistics block: registers, sequencer and sample store.
//
// Keeps the most recent window_size rate samples in a circular store and reports, for every
// input transaction, the fill count, sum, truncated mean, minimum, newest and oldest entries,
// the sum of the newest partial_count entries and the entry lookback steps back. One item is
// handled at a time and input ready is high only while the sequencer is idle; the result waits
// in an output register so the next item can be taken before it is collected. A push reads the
// entry it evicts, writes the sample, rescans the window for the minimum (only when the old
// minimum is evicted) and sums the partial window; a report-only item skips the push and the
// rescan. Each item uses the bit-serial divider for lookback modulo the window length and,
// unless the window is empty, for the mean. All store accesses go through the single read and
// single write port of the RAM. After reset and after every window_size write the store is
// cleared in a pass over all MAX_WINDOW entries, during which no item is accepted.
module sliding_window_stats #(
  parameter int MAX_WINDOW  = sws_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = sws_pkg::DEF_SAMPLE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  sws_item_if.sink                       item,
  sws_result_if.source                   result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sws_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sws_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sws_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import sws_pkg::*;

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int MAX_LEN = (MAX_WINDOW > (2 ** CNT_W - 1)) ? (2 ** CNT_W - 1) : MAX_WINDOW;
  localparam logic [CNT_W-1:0] MAX_LEN_C = CNT_W'(MAX_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_WINDOW - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PUSH0,
    S_PUSH1,
    S_SCAN,
    S_PSUM,
    S_NEW,
    S_OLD,
    S_MOD_GO,
    S_MOD_WAIT,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_DONE
  } state_t;

  state_t state;

  // Configuration and window state.
  logic [CNT_W-1:0]       window_size;
  logic [CNT_W-1:0]       partial_count;
  logic [CNT_W-1:0]       wp;
  logic [CNT_W-1:0]       vc;
  logic [SUM_W-1:0]       run_sum;
  logic [SAMPLE_BITS-1:0] cur_min;
  logic [IDX_W-1:0]       clr_addr;

  // Per-item working registers.
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [LOOK_W-1:0]      lookback_q;
  logic [SAMPLE_BITS-1:0] scan_min;
  logic [CNT_W-1:0]       cnt;
  logic                   pend;
  logic [CNT_W-1:0]       pidx;
  logic [SUM_W-1:0]       psum;
  logic [SAMPLE_BITS-1:0] new_q;
  logic [SAMPLE_BITS-1:0] old_q;
  logic [SAMPLE_BITS-1:0] peek_q;
  logic [WORD_W-1:0]      mean_q;

  // Result register.
  logic                   res_valid;
  logic [CNT_W-1:0]       res_filled;
  logic [SUM_W-1:0]       res_sum;
  logic [WORD_W-1:0]      res_mean;
  logic [WORD_W-1:0]      res_min;
  logic [WORD_W-1:0]      res_newest;
  logic [WORD_W-1:0]      res_oldest;
  logic [SUM_W-1:0]       res_psum;
  logic [WORD_W-1:0]      res_peek;

  // Combinational helpers.
  logic [CNT_W-1:0]       len;
  logic [CNT_W-1:0]       wp_inc;
  logic [CNT_W-1:0]       vc_inc;
  logic [CNT_W-1:0]       part_n;
  logic [CNT_W-1:0]       pidx_dec;
  logic [CNT_W-1:0]       peek_idx;
  logic                   scan_issue;
  logic                   psum_issue;
  logic                   cfg_wr;
  logic                   item_take;

  // Store and divider connections.
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic                   div_start;
  logic [SUM_W-1:0]       div_dividend;
  logic [CNT_W-1:0]       div_divisor;
  logic [SUM_W-1:0]       div_quo;
  logic [CNT_W-1:0]       div_rem;
  div_stat_t              div_stat;

  // Effective window length: zero selects a single entry, large sizes saturate.
  function automatic logic [CNT_W-1:0] win_len(input logic [CNT_W-1:0] ws);
    logic [CNT_W-1:0] l;
    if (ws == '0) begin
      l = CNT_W'(1);
    end else if (ws > MAX_LEN_C) begin
      l = MAX_LEN_C;
    end else begin
      l = ws;
    end
    return l;
  endfunction

  // Pointer arithmetic over the circular window.
  always_comb begin
    len      = win_len(window_size);
    wp_inc   = ({1'b0, wp} + 1'b1 == {1'b0, len}) ? '0 : wp + 1'b1;
    vc_inc   = ({1'b0, vc} + 1'b1 < {1'b0, len}) ? vc + 1'b1 : len;
    part_n   = (partial_count < len) ? partial_count : len;
    pidx_dec = (pidx == '0) ? len - 1'b1 : pidx - 1'b1;
    peek_idx = (wp >= div_rem) ? wp - div_rem : CNT_W'({1'b0, wp} + {1'b0, len} - {1'b0, div_rem});
    scan_issue = cnt < vc;
    psum_issue = cnt < part_n;
  end

  assign cfg_wr    = psel && penable && pwrite && pready;
  assign item_take = item.valid && item.ready;

  // Store port selection by sequencer state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = IDX_W'(wp);
    ram_wdata = sample_q;
    ram_raddr = IDX_W'(wp);
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_PUSH0:    ram_raddr = IDX_W'(wp_inc);
      S_PUSH1:    ram_we    = 1'b1;
      S_SCAN:     ram_raddr = IDX_W'(cnt);
      S_PSUM:     ram_raddr = IDX_W'(pidx);
      S_OLD:      ram_raddr = IDX_W'(wp_inc);
      S_MOD_WAIT: ram_raddr = IDX_W'(peek_idx);
      default:    ram_raddr = IDX_W'(wp);
    endcase
  end

  // Divider requests: lookback modulo length, then sum over count.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = SUM_W'(lookback_q);
    div_divisor  = len;
    case (state)
      S_MOD_GO: div_start = 1'b1;
      S_MEAN_GO: begin
        div_start    = vc != '0;
        div_dividend = run_sum;
        div_divisor  = vc;
      end
      default: div_start = 1'b0;
    endcase
  end

  // Sequencer, window state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      window_size   <= WINDOW_SIZE_RESET;
      partial_count <= PARTIAL_COUNT_RESET;
      wp            <= win_len(WINDOW_SIZE_RESET) - 1'b1;
      vc            <= '0;
      run_sum       <= '0;
      cur_min       <= '0;
      cnt           <= '0;
      pend          <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_IDX) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (item_take) begin
            sample_q   <= item.sample[SAMPLE_BITS-1:0];
            lookback_q <= item.lookback;
            cnt        <= '0;
            pend       <= 1'b0;
            pidx       <= wp;
            psum       <= '0;
            state      <= (item.command == CMD_PUSH) ? S_PUSH0 : S_PSUM;
          end
        end

        // Advance the pointer and fetch the entry being evicted.
        S_PUSH0: begin
          wp    <= wp_inc;
          vc    <= vc_inc;
          state <= S_PUSH1;
        end

        // Write the sample, update the sum and decide on the minimum.
        S_PUSH1: begin
          run_sum  <= run_sum - SUM_W'(ram_rdata) + SUM_W'(sample_q);
          scan_min <= sample_q;
          pidx     <= wp;
          if (sample_q <= cur_min) begin
            cur_min <= sample_q;
            state   <= S_PSUM;
          end else if (ram_rdata == cur_min) begin
            state <= S_SCAN;
          end else begin
            state <= S_PSUM;
          end
        end

        // Rescan entries 0 to count-1 for the new minimum, one read per cycle.
        S_SCAN: begin
          if (pend && ram_rdata < scan_min) begin
            scan_min <= ram_rdata;
          end
          if (scan_issue) begin
            cnt <= cnt + 1'b1;
          end
          pend <= scan_issue;
          if (!scan_issue && !pend) begin
            cur_min <= scan_min;
            cnt     <= '0;
            state   <= S_PSUM;
          end
        end

        // Walk back from the newest entry, summing the partial window.
        S_PSUM: begin
          if (pend) begin
            psum <= psum + SUM_W'(ram_rdata);
          end
          if (psum_issue) begin
            cnt  <= cnt + 1'b1;
            pidx <= pidx_dec;
          end
          pend <= psum_issue;
          if (!psum_issue && !pend) begin
            state <= S_NEW;
          end
        end

        S_NEW: state <= S_OLD;

        S_OLD: begin
          new_q <= ram_rdata;
          state <= S_MOD_GO;
        end

        S_MOD_GO: begin
          old_q <= ram_rdata;
          state <= S_MOD_WAIT;
        end

        // The peek address is issued in the cycle the remainder is ready.
        S_MOD_WAIT: begin
          if (div_stat.done) begin
            state <= S_MEAN_GO;
          end
        end

        S_MEAN_GO: begin
          peek_q <= ram_rdata;
          if (vc == '0) begin
            mean_q <= '0;
            state  <= S_DONE;
          end else begin
            state <= S_MEAN_WAIT;
          end
        end

        S_MEAN_WAIT: begin
          if (div_stat.done) begin
            mean_q <= div_quo[WORD_W-1:0];
            state  <= S_DONE;
          end
        end

        // Hand the statistics to the result register once it is free.
        S_DONE: begin
          if (!res_valid || result.ready) begin
            res_valid  <= 1'b1;
            res_filled <= vc;
            res_sum    <= (window_size == '0) ? '0 : run_sum;
            res_mean   <= mean_q;
            res_min    <= WORD_W'(cur_min);
            res_newest <= WORD_W'(new_q);
            res_oldest <= WORD_W'(old_q);
            res_psum   <= psum;
            res_peek   <= WORD_W'(peek_q);
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase

      // Register writes; a window size write restarts the window and clears the store.
      if (cfg_wr) begin
        case (paddr[2])
          REG_WINDOW_SIZE: begin
            window_size <= pwdata[CNT_W-1:0];
            wp          <= win_len(pwdata[CNT_W-1:0]) - 1'b1;
            vc          <= '0;
            run_sum     <= '0;
            cur_min     <= '0;
            clr_addr    <= '0;
            state       <= S_CLEAR;
          end
          REG_PARTIAL_COUNT: partial_count <= pwdata[CNT_W-1:0];
          default: partial_count <= partial_count;
        endcase
      end
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[2])
      REG_WINDOW_SIZE:   prdata = APB_DATA_W'(window_size);
      REG_PARTIAL_COUNT: prdata = APB_DATA_W'(partial_count);
      default:           prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Channel outputs.
  assign item.ready         = state == S_IDLE;
  assign result.valid       = res_valid;
  assign result.filled      = res_filled;
  assign result.window_sum  = res_sum;
  assign result.window_mean = res_mean;
  assign result.window_min  = res_min;
  assign result.newest      = res_newest;
  assign result.oldest      = res_oldest;
  assign result.partial_sum = res_psum;
  assign result.peek_value  = res_peek;

  sws_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sws_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

`ifndef SYNTHESIS
  // The write pointer always lies inside the current window.
  a_wp_in_window: assert property (@(posedge clk) disable iff (rst) wp < len)
    else $error("write pointer outside the window");

  // The fill count never exceeds the window length.
  a_count_bounded: assert property (@(posedge clk) disable iff (rst) vc <= len)
    else $error("fill count above window length");

  // The divider is never started while a division is still running.
  a_div_free: assert property (@(posedge clk) disable iff (rst) div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // A new result appears only when the sequencer finishes an item.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the finish step");
`endif

endmodule

>>> bench/tb_sliding_window_stats.sv
// Self-checking testbench for the sliding window statistics block.
module tb_sliding_window_stats;
  timeunit 1ns;
  timeprecision 1ps;

  import sws_pkg::*;

  localparam int STORE_DEPTH    = DEF_MAX_WINDOW;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 250;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 116;

  // One set of window statistics, as carried by a result transaction.
  typedef struct packed {
    logic [CNT_W-1:0]  filled;
    logic [SUM_W-1:0]  window_sum;
    logic [WORD_W-1:0] window_mean;
    logic [WORD_W-1:0] window_min;
    logic [WORD_W-1:0] newest;
    logic [WORD_W-1:0] oldest;
    logic [SUM_W-1:0]  partial_sum;
    logic [WORD_W-1:0] peek_value;
  } stats_t;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

  // One line of the directed stimulus table.
  typedef struct {
    row_kind_t         kind;
    logic              reg_idx;
    logic [CNT_W-1:0]  reg_val;
    logic [CMD_W-1:0]  command;
    logic [WORD_W-1:0] sample;
    logic [LOOK_W-1:0] lookback;
    bit                typed;
    stats_t            want;
  } row_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  sws_item_if   item_bus ();
  sws_result_if stat_bus ();

  sliding_window_stats uut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_bus),
    .result  (stat_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the block state and its registers.
  logic [WORD_W-1:0] rate_store [STORE_DEPTH];
  int                wr_ptr;
  int                fill_count;
  logic [SUM_W-1:0]  run_sum;
  logic [WORD_W-1:0] cur_min;
  logic [CNT_W-1:0]  cfg_window;
  logic [CNT_W-1:0]  cfg_partial;

  stats_t expected_stats [$];
  row_t   directed_rows [$];
  int     mismatches;
  int     idle_cycles;
  bit     calm;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Number of entries the window actually holds.
  function automatic int span();
    if (cfg_window == 0) return 1;
    if (int'(cfg_window) > STORE_DEPTH) return STORE_DEPTH;
    return int'(cfg_window);
  endfunction

  // A window size write empties the window and parks the pointer at its last entry.
  function automatic void clear_window();
    foreach (rate_store[i]) rate_store[i] = '0;
    wr_ptr     = span() - 1;
    fill_count = 0;
    run_sum    = '0;
    cur_min    = '0;
  endfunction

  // Entry some steps before the newest one, wrapping within the window.
  function automatic logic [WORD_W-1:0] back_entry(int back, int len);
    return rate_store[(wr_ptr + len - (back % len)) % len];
  endfunction

  // Overwrite the oldest entry and keep the sum and minimum current.
  function automatic void apply_push(logic [WORD_W-1:0] value);
    int                len;
    logic [WORD_W-1:0] evicted;
    logic [WORD_W-1:0] lowest;
    logic [WORD_W-1:0] v;
    len        = span();
    fill_count = (fill_count + 1 < len) ? fill_count + 1 : len;
    wr_ptr     = (wr_ptr + 1) % len;
    evicted    = rate_store[wr_ptr];
    run_sum    = run_sum - SUM_W'(evicted) + SUM_W'(value);
    if (value <= cur_min) begin
      cur_min = value;
    end else if (evicted == cur_min) begin
      // The minimum just left the window, so look over the valid entries again.
      lowest = value;
      for (int i = 0; i < fill_count && i < STORE_DEPTH; i++) begin
        v = (i == wr_ptr) ? value : rate_store[i];
        if (v < lowest) lowest = v;
      end
      cur_min = lowest;
    end
    rate_store[wr_ptr] = value;
  endfunction

  // Apply one accepted item to the mirror and return the statistics it reports.
  function automatic stats_t predict_stats(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] smp,
                                           logic [LOOK_W-1:0] look);
    stats_t           s;
    int               len;
    int               n;
    logic [SUM_W-1:0] psum;
    logic [SUM_W-1:0] quot;
    if (cmd == CMD_PUSH) apply_push(smp);
    len  = span();
    n    = (int'(cfg_partial) < len) ? int'(cfg_partial) : len;
    psum = '0;
    for (int k = 0; k < n; k++) psum = psum + SUM_W'(back_entry(k, len));
    quot          = (fill_count != 0) ? run_sum / SUM_W'(fill_count) : '0;
    s.filled      = CNT_W'(fill_count);
    s.window_sum  = (cfg_window == 0) ? '0 : run_sum;
    s.window_mean = quot[WORD_W-1:0];
    s.window_min  = cur_min;
    s.newest      = rate_store[wr_ptr % len];
    s.oldest      = rate_store[(wr_ptr + 1) % len];
    s.partial_sum = psum;
    s.peek_value  = back_entry(int'(look), len);
    return s;
  endfunction

  // Mostly short gaps, some medium ones, a few long ones; none in a calm stretch.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Rate values biased toward extremes and repeats so the minimum gets evicted often.
  function automatic logic [WORD_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return WORD_W'($urandom_range(0, 15));
      5, 6:    return WORD_W'($urandom_range(0, 1000));
      default: return WORD_W'($urandom);
    endcase
  endfunction

  function automatic void add_write(logic idx, logic [CNT_W-1:0] val);
    row_t r;
    r         = '{kind: ROW_WRITE, default: '0};
    r.reg_idx = idx;
    r.reg_val = val;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_item(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] smp,
                                   logic [LOOK_W-1:0] look, bit typed, stats_t want);
    row_t r;
    r          = '{kind: ROW_ITEM, default: '0};
    r.command  = cmd;
    r.sample   = smp;
    r.lookback = look;
    r.typed    = typed;
    r.want     = want;
    directed_rows.push_back(r);
  endfunction

  // Offer one item after a random gap and record its expected statistics on acceptance.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] smp,
                           input logic [LOOK_W-1:0] look, input bit typed, input stats_t want);
    int     gap;
    stats_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid    <= 1'b1;
    item_bus.command  <= cmd;
    item_bus.sample   <= smp;
    item_bus.lookback <= look;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    pred = predict_stats(cmd, smp, look);
    expected_stats.push_back(typed ? want : pred);
  endtask

  // Wait for the window to go quiet, then write a register and read it back.
  task automatic write_reg(input logic idx, input logic [CNT_W-1:0] val);
    logic [APB_DATA_W-1:0] got;
    item_bus.valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_WINDOW_SIZE) begin
      cfg_window = val;
      clear_window();
    end else begin
      cfg_partial = val;
    end
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got != APB_DATA_W'(val)) begin
      $display("%0t: register %0d readback expected %0h got %0h", $time, idx, val, got);
      mismatches++;
    end
  endtask

  function automatic void check_field(string name, logic [SUM_W-1:0] want,
                                      logic [SUM_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every result transaction against the oldest expectation.
  always @(posedge clk) begin
    stats_t want;
    if (!rst && stat_bus.valid && stat_bus.ready) begin
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none got filled %0h", $time,
                 stat_bus.filled);
        mismatches++;
      end else begin
        want = expected_stats.pop_front();
        check_field("filled", SUM_W'(want.filled), SUM_W'(stat_bus.filled));
        check_field("window_sum", want.window_sum, stat_bus.window_sum);
        check_field("window_mean", SUM_W'(want.window_mean), SUM_W'(stat_bus.window_mean));
        check_field("window_min", SUM_W'(want.window_min), SUM_W'(stat_bus.window_min));
        check_field("newest", SUM_W'(want.newest), SUM_W'(stat_bus.newest));
        check_field("oldest", SUM_W'(want.oldest), SUM_W'(stat_bus.oldest));
        check_field("partial_sum", want.partial_sum, stat_bus.partial_sum);
        check_field("peek_value", SUM_W'(want.peek_value), SUM_W'(stat_bus.peek_value));
      end
    end
  end

  // Count cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) || (stat_bus.valid && stat_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // Result side: ready drops for random stretches.
  initial begin
    int stall;
    stat_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        stat_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      stat_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Stimulus: directed table first, then random phases with fresh settings.
  initial begin
    logic [CNT_W-1:0] ws;
    stats_t           none;
    mismatches  = 0;
    calm        = 1'b0;
    none        = '0;
    cfg_window  = WINDOW_SIZE_RESET;
    cfg_partial = PARTIAL_COUNT_RESET;
    clear_window();

    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    item_bus.valid    <= 1'b0;
    item_bus.command  <= CMD_REPORT;
    item_bus.sample   <= '0;
    item_bus.lookback <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Fresh from reset: last-value-only mode with an empty store.
    add_item(CMD_REPORT, 32'h1234_5678, 6'd0, 1'b1, '0);
    add_item(CMD_PUSH, 32'hFFFF_FFFF, 6'd63, 1'b1,
             '{7'd1, 38'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               38'hFFFF_FFFF, 32'hFFFF_FFFF});
    add_item(CMD_PUSH, 32'h0, 6'd0, 1'b1, '{7'd1, 38'd0, 32'd0, 32'd0, 32'd0, 32'd0, 38'd0,
                                            32'd0});
    // Largest window, summing everything.
    add_write(REG_WINDOW_SIZE, 7'd64);
    add_write(REG_PARTIAL_COUNT, 7'd64);
    add_item(CMD_PUSH, 32'hFFFF_FFFF, 6'd0, 1'b0, none);
    add_item(CMD_PUSH, 32'hFFFF_FFFF, 6'd1, 1'b0, none);
    add_item(CMD_PUSH, 32'h1, 6'd63, 1'b0, none);
    add_item(CMD_REPORT, 32'hFFFF_FFFF, 6'd2, 1'b0, none);
    add_item(CMD_PUSH, 32'h0, 6'd5, 1'b0, none);
    // Small window: fill it, evict a non-minimum, then evict the minimum.
    add_write(REG_WINDOW_SIZE, 7'd3);
    add_write(REG_PARTIAL_COUNT, 7'd0);
    add_item(CMD_PUSH, 32'd5, 6'd0, 1'b0, none);
    add_item(CMD_PUSH, 32'd3, 6'd1, 1'b0, none);
    add_item(CMD_PUSH, 32'd7, 6'd2, 1'b0, none);
    add_item(CMD_PUSH, 32'd9, 6'd3, 1'b0, none);
    add_item(CMD_PUSH, 32'd8, 6'd4, 1'b0, none);
    add_item(CMD_PUSH, 32'd3, 6'd4, 1'b0, none);
    add_item(CMD_REPORT, 32'd0, 6'd63, 1'b0, none);
    // Window size and partial count both beyond the store depth.
    add_write(REG_WINDOW_SIZE, 7'd127);
    add_write(REG_PARTIAL_COUNT, 7'd127);
    add_item(CMD_PUSH, 32'hAAAA_AAAA, 6'd0, 1'b0, none);
    add_item(CMD_PUSH, 32'h5555_5555, 6'd63, 1'b0, none);
    add_item(CMD_REPORT, 32'h0, 6'd0, 1'b0, none);
    // Single-entry window.
    add_write(REG_WINDOW_SIZE, 7'd1);
    add_write(REG_PARTIAL_COUNT, 7'd1);
    add_item(CMD_PUSH, 32'd7, 6'd0, 1'b0, none);
    add_item(CMD_PUSH, 32'd2, 6'd63, 1'b0, none);
    add_item(CMD_REPORT, 32'd9, 6'd63, 1'b0, none);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_item(directed_rows[i].command, directed_rows[i].sample,
                  directed_rows[i].lookback, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases, each with its own window setting.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 9))
        0:       ws = 7'd0;
        1:       ws = 7'd1;
        2, 3, 4: ws = CNT_W'($urandom_range(2, 8));
        5:       ws = 7'd64;
        6:       ws = CNT_W'($urandom_range(65, 127));
        default: ws = CNT_W'($urandom_range(2, 127));
      endcase
      write_reg(REG_WINDOW_SIZE, ws);
      write_reg(REG_PARTIAL_COUNT, CNT_W'($urandom_range(0, 127)));
      calm = (p == 0) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(($urandom_range(0, 4) == 0) ? CMD_REPORT : CMD_PUSH, pick_sample(),
                  LOOK_W'($urandom_range(0, 63)), 1'b0, none);
      end
    end
    calm = 1'b0;
    item_bus.valid <= 1'b0;

    while (expected_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
